// ----- rtl/splr_pkg.sv -----
// Shared constants and types of the splat layer paint and renormalisation unit.
package splr_pkg;

    localparam int NUM_W                = 8;
    localparam int IDX_BITS             = 3;
    localparam int LC_BITS              = 4;
    localparam int TGT_BITS             = 3;
    localparam int CFG_IDX_BITS         = 1;
    localparam int CFG_DATA_BITS        = 4;

    localparam int DEF_MAX_LAYERS       = 8;
    localparam int DEF_WEIGHT_FRAC_BITS = 16;
    localparam int DEF_COUNT_BITS       = 24;

    localparam logic [LC_BITS-1:0]      LC_RESET  = 4'd4;
    localparam logic [TGT_BITS-1:0]     TGT_RESET = 3'd0;
    localparam logic [IDX_BITS-1:0]     IDX_LAST  = 3'd7;

    localparam logic [CFG_IDX_BITS-1:0] REG_LAYER_COUNT  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_LAYER = 1'b1;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_stat;

endpackage

// ----- rtl/splr_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module splr_mul #(
    parameter int W = splr_pkg::DEF_WEIGHT_FRAC_BITS + 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic           o_done,
    output logic [2*W-1:0] o_prod
);

    localparam int CW = $clog2(W + 1);

    logic [2*W-1:0] r_prod;
    logic [W-1:0]   r_a;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [W:0]     sum;

    // add the multiplicand into the upper half, then shift right by one
    assign sum = {1'b0, r_prod[2*W-1:W]} + (r_prod[0] ? {1'b0, r_a} : {(W+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_prod <= {{W{1'b0}}, i_b};
                r_a    <= i_a;
                r_cnt  <= CW'(W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_prod <= {sum, r_prod[W-1:1]};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

// ----- rtl/splr_div.sv -----
// Bit-serial restoring divider with quotient overflow detection.
module splr_div #(
    parameter int W = splr_pkg::DEF_WEIGHT_FRAC_BITS + 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [2*W-1:0]      i_num,
    input  logic [W-1:0]        i_den,
    output splr_pkg::t_div_stat o_stat,
    output logic [W-1:0]        o_quot
);

    localparam int CW = $clog2(W + 1);

    logic [2*W-1:0] r_rq;
    logic [W-1:0]   r_den;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic           r_ovf;
    logic [W:0]     shifted;
    logic           ge;
    logic [W:0]     rem_n;

    // one quotient bit a cycle: shift remainder, trial subtract
    assign shifted = {r_rq[2*W-1:W], r_rq[W-1]};
    assign ge      = shifted >= {1'b0, r_den};
    assign rem_n   = ge ? (shifted - {1'b0, r_den}) : shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rq  <= i_num;
                r_den <= i_den;
                // upper half not below divisor: quotient needs more than W bits
                if (i_num[2*W-1:W] >= i_den) begin
                    r_ovf  <= 1'b1;
                    r_done <= 1'b1;
                end else begin
                    r_ovf  <= 1'b0;
                    r_cnt  <= CW'(W);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rq  <= {rem_n[W-1:0], r_rq[W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;
    assign o_quot      = r_rq[W-1:0];

endmodule

// ----- rtl/splat_layer_paint_renorm_unit.sv -----
// Top level of the splat layer paint and renormalisation unit.
//
// One request carries the eight layer weights of a texel, a paint value and
// a last-texel mark; one result request comes back for each. The target
// layer takes the paint value and every other active layer is rescaled as
// floor(w*(ONE-paint)/(ONE-old)), saturated to ONE, or, when the old target
// weight was already ONE, set to floor((ONE-paint)/(layers-1)). Inputs above
// ONE are taken as ONE, inactive layers read as zero. A target beyond the
// active layers passes the weights through; a single layer with paint below
// ONE passes them through and raises paint_error. All rescaling runs through
// one bit-serial multiplier followed by one bit-serial divider, one layer
// after the other; a quotient that overflows skips its divide pass. A new
// request is taken once the previous one has moved into the output
// register, even while that result still waits to be taken. The
// changed-texel count saturates and clears after the result marked
// pass_done. Configuration writes land at once and must only be made while
// the unit is idle.
module splat_layer_paint_renorm_unit #(
    parameter int MAX_LAYERS       = splr_pkg::DEF_MAX_LAYERS,
    parameter int WEIGHT_FRAC_BITS = splr_pkg::DEF_WEIGHT_FRAC_BITS,
    parameter int COUNT_BITS       = splr_pkg::DEF_COUNT_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [splr_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [splr_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    // input requests
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [WEIGHT_FRAC_BITS:0]          i_weight_layer_0,
    input  logic [WEIGHT_FRAC_BITS:0]          i_weight_layer_1,
    input  logic [WEIGHT_FRAC_BITS:0]          i_weight_layer_2,
    input  logic [WEIGHT_FRAC_BITS:0]          i_weight_layer_3,
    input  logic [WEIGHT_FRAC_BITS:0]          i_weight_layer_4,
    input  logic [WEIGHT_FRAC_BITS:0]          i_weight_layer_5,
    input  logic [WEIGHT_FRAC_BITS:0]          i_weight_layer_6,
    input  logic [WEIGHT_FRAC_BITS:0]          i_weight_layer_7,
    input  logic [WEIGHT_FRAC_BITS:0]          i_paint_value,
    input  logic                               i_last_texel,
    // result requests
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [WEIGHT_FRAC_BITS:0]          o_new_weight_0,
    output logic [WEIGHT_FRAC_BITS:0]          o_new_weight_1,
    output logic [WEIGHT_FRAC_BITS:0]          o_new_weight_2,
    output logic [WEIGHT_FRAC_BITS:0]          o_new_weight_3,
    output logic [WEIGHT_FRAC_BITS:0]          o_new_weight_4,
    output logic [WEIGHT_FRAC_BITS:0]          o_new_weight_5,
    output logic [WEIGHT_FRAC_BITS:0]          o_new_weight_6,
    output logic [WEIGHT_FRAC_BITS:0]          o_new_weight_7,
    output logic                               o_texel_changed,
    output logic [COUNT_BITS-1:0]              o_changed_total,
    output logic                               o_paint_error,
    output logic                               o_pass_done
);

    import splr_pkg::*;

    localparam int W = WEIGHT_FRAC_BITS + 1;
    localparam logic [W-1:0]          ONE     = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [LC_BITS-1:0]    LC_MAX  = LC_BITS'(MAX_LAYERS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // configuration registers
    logic [LC_BITS-1:0]  r_layer_count;
    logic [TGT_BITS-1:0] r_target;

    // control state
    t_state              r_state, n_state;
    logic [IDX_BITS-1:0] r_idx, n_idx;
    logic                r_out_vld, n_out_vld;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;

    // working set of the request in flight
    logic [W-1:0]        r_w [NUM_W];
    logic [W-1:0]        r_rest;
    logic [W-1:0]        r_den;
    logic                r_full;
    logic                r_changed;
    logic                r_err;
    logic                r_last;
    logic [LC_BITS-1:0]  r_layers;
    logic [TGT_BITS-1:0] r_tgt;

    // output register
    logic [W-1:0]          r_o_w [NUM_W];
    logic                  r_o_changed;
    logic [COUNT_BITS-1:0] r_o_total;
    logic                  r_o_err;
    logic                  r_o_done;

    // decode of the incoming request
    logic [W-1:0]       in_w   [NUM_W];
    logic [W-1:0]       in_sat [NUM_W];
    logic [LC_BITS-1:0] layers_c;
    logic [W-1:0]       paint_c;
    logic [W-1:0]       old_c;
    logic               pass_c;
    logic               err_c;
    logic               proc_c;
    logic               in_acc;

    // sequencing
    logic               work_c;
    logic               mul_start;
    logic               mul_done;
    logic [2*W-1:0]     mul_prod;
    logic [W-1:0]       mul_a;
    logic               div_start;
    t_div_stat          div_stat;
    logic [W-1:0]       div_quot;
    logic [W-1:0]       q_sat;
    logic               load;
    logic               out_take;
    logic [COUNT_BITS-1:0] cnt_inc;

    assign in_w[0] = i_weight_layer_0;
    assign in_w[1] = i_weight_layer_1;
    assign in_w[2] = i_weight_layer_2;
    assign in_w[3] = i_weight_layer_3;
    assign in_w[4] = i_weight_layer_4;
    assign in_w[5] = i_weight_layer_5;
    assign in_w[6] = i_weight_layer_6;
    assign in_w[7] = i_weight_layer_7;

    // clamp the layer count into 1..MAX_LAYERS
    always_comb begin
        layers_c = r_layer_count;
        if (r_layer_count == '0) begin
            layers_c = LC_BITS'(1);
        end else if (r_layer_count > LC_MAX) begin
            layers_c = LC_MAX;
        end
    end

    // saturate weights to ONE, zero the inactive layers
    always_comb begin
        for (int i = 0; i < NUM_W; i++) begin
            if (LC_BITS'(i) < layers_c) begin
                in_sat[i] = (in_w[i] > ONE) ? ONE : in_w[i];
            end else begin
                in_sat[i] = '0;
            end
        end
    end

    assign paint_c = (i_paint_value > ONE) ? ONE : i_paint_value;
    assign old_c   = in_sat[r_target];
    assign pass_c  = {1'b0, r_target} >= layers_c;
    assign err_c   = !pass_c && (layers_c == LC_BITS'(1)) && (paint_c != ONE);
    assign proc_c  = !pass_c && !err_c;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // a slot needs rescaling when it is active and not the target
    assign work_c    = ({1'b0, r_idx} < r_layers) && (r_idx != r_tgt);
    assign mul_start = (r_state == S_SCAN) && work_c;
    assign div_start = (r_state == S_MUL) && mul_done;
    assign mul_a     = r_full ? W'(1) : r_w[r_idx];
    assign q_sat     = (div_stat.ovf || (div_quot > ONE)) ? ONE : div_quot;

    assign out_take = r_out_vld && i_out_ready;
    assign load     = (r_state == S_DONE) && (!r_out_vld || i_out_ready);
    assign cnt_inc  = (r_changed && (r_cnt != CNT_MAX)) ? (r_cnt + 1'b1) : r_cnt;

    splr_mul #(
        .W (W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (r_rest),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    splr_div #(
        .W (W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mul_prod),
        .i_den   (r_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // sequencer next state
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_out_vld = r_out_vld;
        n_cnt     = r_cnt;
        if (out_take) begin
            n_out_vld = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx   = '0;
                    n_state = proc_c ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (work_c) begin
                    n_state = S_MUL;
                end else if (r_idx == IDX_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    if (r_idx == IDX_LAST) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_DONE: begin
                if (load) begin
                    n_out_vld = 1'b1;
                    // clear the count once the last texel is counted
                    n_cnt     = r_last ? '0 : cnt_inc;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_idx         <= '0;
            r_out_vld     <= 1'b0;
            r_cnt         <= '0;
            r_layer_count <= LC_RESET;
            r_target      <= TGT_RESET;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
            r_cnt     <= n_cnt;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LAYER_COUNT:  r_layer_count <= i_cfg_data[LC_BITS-1:0];
                    REG_TARGET_LAYER: r_target      <= i_cfg_data[TGT_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // working set: capture on accept, write back each rescaled weight
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int i = 0; i < NUM_W; i++) begin
                r_w[i] <= (proc_c && (TGT_BITS'(i) == r_target)) ? paint_c : in_sat[i];
            end
            r_rest    <= ONE - paint_c;
            r_full    <= (old_c == ONE);
            r_den     <= (old_c == ONE) ? W'(layers_c - 1'b1) : (ONE - old_c);
            r_changed <= proc_c && (old_c != paint_c);
            r_err     <= err_c;
            r_last    <= i_last_texel;
            r_layers  <= layers_c;
            r_tgt     <= r_target;
        end else if ((r_state == S_DIV) && div_stat.done) begin
            r_w[r_idx] <= q_sat;
        end
    end

    // output register: hold until taken, refill only when free
    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int i = 0; i < NUM_W; i++) begin
                r_o_w[i] <= r_w[i];
            end
            r_o_changed <= r_changed;
            r_o_total   <= cnt_inc;
            r_o_err     <= r_err;
            r_o_done    <= r_last;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_new_weight_0  = r_o_w[0];
    assign o_new_weight_1  = r_o_w[1];
    assign o_new_weight_2  = r_o_w[2];
    assign o_new_weight_3  = r_o_w[3];
    assign o_new_weight_4  = r_o_w[4];
    assign o_new_weight_5  = r_o_w[5];
    assign o_new_weight_6  = r_o_w[6];
    assign o_new_weight_7  = r_o_w[7];
    assign o_texel_changed = r_o_changed;
    assign o_changed_total = r_o_total;
    assign o_paint_error   = r_o_err;
    assign o_pass_done     = r_o_done;

    // the multiplier only finishes while the sequencer waits for it
    a_mul_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MUL))
        else $error("multiplier finished outside its wait state");

    // the divider only finishes while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    // the changed count only falls when the last texel's result is loaded
    a_cnt_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(load && r_last) |-> (r_cnt >= $past(r_cnt)))
        else $error("changed count dropped without a pass end");

endmodule
